### rtl/core/clle_pkg.sv
// Package for the cursor linked list engine: op codes, status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package clle_pkg;
   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_W = 32;
   localparam int OP_W = 4;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 7;

   typedef enum logic [3:0] {
      OP_INS_FRONT  = 4'd0,
      OP_INS_BACK   = 4'd1,
      OP_INS_BEFORE = 4'd2,
      OP_DEL_FIRST  = 4'd3,
      OP_DEL_LAST   = 4'd4,
      OP_DEL_CURSOR = 4'd5,
      OP_MV_FIRST   = 4'd6,
      OP_MV_LAST    = 4'd7,
      OP_MV_PREV    = 4'd8,
      OP_MV_NEXT    = 4'd9,
      OP_CLEAR      = 4'd10,
      OP_QUERY      = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_OFF_END  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_WB,
      S_VAL_TAIL,
      S_VAL_CUR,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

### rtl/core/clle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module clle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/cursor_linked_list_engine_unit.sv
// Top level of the cursor linked list engine: FSM, list registers, node memories.
// Depends on clle_pkg and clle_ram.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; the one result beat
// appears on the rsp_ ports for a single cycle with rsp_valid high and cannot
// be stalled. Every op takes the same path: a link read, the node update, the
// neighbor link write back (overlapped with the first value read), then the
// last and cursor value reads on the one value read port. The result beat is
// in S_RESP, and busy stays high from the accepting edge until the FSM is
// back in S_IDLE, so the next request is taken only after that beat.
// Node memories need no clearing: the free list and the fresh count never
// reach an unwritten slot.
module cursor_linked_list_engine_unit
   import clle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [OP_W-1:0]            req_op,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output logic                            rsp_valid,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic signed [VALUE_W-1:0]       rsp_first_value,
   output logic signed [VALUE_W-1:0]       rsp_last_value,
   output logic signed [VALUE_W-1:0]       rsp_cursor_value,
   output logic [LENGTH_W-1:0]             rsp_length,
   output logic                            rsp_is_empty,
   output logic                            rsp_off_end,
   output logic                            rsp_at_first,
   output logic                            rsp_at_last
);
   localparam int AW = $clog2(CAPACITY);
   localparam int IW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);

   state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [IW-1:0] free_ff, free_in, fresh_ff, fresh_in, cnt_ff, cnt_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   status_type st_ff, st_in;
   logic [VALUE_W-1:0] fv_ff, fv_in, lv_ff, lv_in;
   // neighbor link writes, registered in S_EXEC and applied in S_WB
   logic wn_ff, wn_in, wp_ff, wp_in;
   logic [IW-1:0] wna_ff, wna_in, wnd_ff, wnd_in, wpa_ff, wpa_in, wpd_ff, wpd_in;

   logic ne_we, pe_we, ve_we;
   logic [AW-1:0] ne_wa, pe_wa, ve_wa, ne_ra, pe_ra, ve_ra;
   logic [IW-1:0] ne_wd, pe_wd, ne_rd, pe_rd;
   logic [VALUE_W-1:0] ve_wd, ve_rd;

   clle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(ne_we), .wr_addr(ne_wa), .wr_data(ne_wd),
      .rd_addr(ne_ra), .rd_data(ne_rd));
   clle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(pe_we), .wr_addr(pe_wa), .wr_data(pe_wd),
      .rd_addr(pe_ra), .rd_data(pe_rd));
   clle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val (
      .clock(clock), .wr_en(ve_we), .wr_addr(ve_wa), .wr_data(ve_wd),
      .rd_addr(ve_ra), .rd_data(ve_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= NIL;
         tail_ff <= NIL;
         cur_ff <= NIL;
         free_ff <= NIL;
         fresh_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cur_ff <= cur_in;
         free_ff <= free_in;
         fresh_ff <= fresh_in;
         cnt_ff <= cnt_in;
      end
      op_ff <= op_in;
      val_ff <= val_in;
      st_ff <= st_in;
      fv_ff <= fv_in;
      lv_ff <= lv_in;
      wn_ff <= wn_in;
      wp_ff <= wp_in;
      wna_ff <= wna_in;
      wnd_ff <= wnd_in;
      wpa_ff <= wpa_in;
      wpd_ff <= wpd_in;
   end

   logic empty, off, can_take, from_free, ins_op;
   logic [IW-1:0] slot, nxt, prv, target;

   assign empty = head_ff >= NIL;
   assign off = cur_ff >= NIL;
   assign from_free = free_ff < NIL;
   assign can_take = from_free || fresh_ff < NIL;
   assign slot = from_free ? free_ff : fresh_ff;
   assign nxt = (ne_rd > NIL) ? NIL : ne_rd;
   assign prv = (pe_rd > NIL) ? NIL : pe_rd;
   assign ins_op = op_ff == OP_INS_FRONT || op_ff == OP_INS_BACK || op_ff == OP_INS_BEFORE;

   always_comb begin
      unique case (op_ff)
         OP_DEL_FIRST: target = head_ff;
         OP_DEL_LAST:  target = tail_ff;
         default:      target = cur_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cur_in = cur_ff;
      free_in = free_ff;
      fresh_in = fresh_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      val_in = val_ff;
      st_in = st_ff;
      fv_in = fv_ff;
      lv_in = lv_ff;
      wn_in = 1'b0;
      wp_in = 1'b0;
      wna_in = wna_ff;
      wnd_in = wnd_ff;
      wpa_in = wpa_ff;
      wpd_in = wpd_ff;
      ne_we = 1'b0;
      pe_we = 1'b0;
      ve_we = 1'b0;
      ne_wa = '0;
      pe_wa = '0;
      ve_wa = '0;
      ne_wd = '0;
      pe_wd = '0;
      ve_wd = '0;
      ne_ra = '0;
      pe_ra = '0;
      ve_ra = '0;
      busy = state_ff != S_IDLE;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_op;
               val_in = req_value;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // read links of the target node; for inserts, next is read from the free head
            ne_ra = ins_op ? free_ff[AW-1:0] : target[AW-1:0];
            pe_ra = target[AW-1:0];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            st_in = ST_OK;
            state_in = S_WB;
            unique case (op_ff)
               OP_INS_FRONT, OP_INS_BACK, OP_INS_BEFORE: begin
                  if (op_ff == OP_INS_BEFORE && off) st_in = ST_OFF_END;
                  else if (!can_take) st_in = ST_FULL;
                  else begin
                     if (from_free) free_in = nxt;
                     else fresh_in = fresh_ff + 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                     ve_we = 1'b1;
                     ve_wa = slot[AW-1:0];
                     ve_wd = val_ff;
                     ne_we = 1'b1;
                     ne_wa = slot[AW-1:0];
                     pe_we = 1'b1;
                     pe_wa = slot[AW-1:0];
                     if (empty) begin
                        ne_wd = NIL;
                        pe_wd = NIL;
                        head_in = slot;
                        tail_in = slot;
                        cur_in = slot;
                     end else if (op_ff == OP_INS_BACK) begin
                        ne_wd = NIL;
                        pe_wd = tail_ff;
                        tail_in = slot;
                        wn_in = 1'b1;
                        wna_in = tail_ff;
                        wnd_in = slot;
                     end else if (op_ff == OP_INS_FRONT || cur_ff == head_ff) begin
                        ne_wd = head_ff;
                        pe_wd = NIL;
                        head_in = slot;
                        wp_in = 1'b1;
                        wpa_in = head_ff;
                        wpd_in = slot;
                     end else begin
                        ne_wd = cur_ff;
                        pe_wd = prv;
                        wp_in = 1'b1;
                        wpa_in = cur_ff;
                        wpd_in = slot;
                        wn_in = 1'b1;
                        wna_in = prv;
                        wnd_in = slot;
                     end
                  end
               end
               OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_CURSOR: begin
                  if (empty) st_in = ST_EMPTY;
                  else if (op_ff == OP_DEL_CURSOR && off) st_in = ST_OFF_END;
                  else begin
                     if (prv >= NIL) head_in = nxt;
                     else begin
                        wn_in = 1'b1;
                        wna_in = prv;
                        wnd_in = nxt;
                     end
                     if (nxt >= NIL) tail_in = prv;
                     else begin
                        wp_in = 1'b1;
                        wpa_in = nxt;
                        wpd_in = prv;
                     end
                     if (cur_ff == target) cur_in = NIL;
                     if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                     ne_we = 1'b1;
                     ne_wa = target[AW-1:0];
                     ne_wd = free_ff;
                     pe_we = 1'b1;
                     pe_wa = target[AW-1:0];
                     pe_wd = NIL;
                     free_in = target;
                  end
               end
               OP_MV_FIRST: begin
                  if (empty) st_in = ST_EMPTY; else cur_in = head_ff;
               end
               OP_MV_LAST: begin
                  if (empty) st_in = ST_EMPTY; else cur_in = tail_ff;
               end
               OP_MV_PREV: begin
                  if (off) st_in = ST_OFF_END; else cur_in = prv;
               end
               OP_MV_NEXT: begin
                  if (off) st_in = ST_OFF_END; else cur_in = nxt;
               end
               OP_CLEAR: begin
                  if (!empty) begin
                     ne_we = 1'b1;
                     ne_wa = tail_ff[AW-1:0];
                     ne_wd = free_ff;
                     free_in = head_ff;
                     head_in = NIL;
                     tail_in = NIL;
                     cur_in = NIL;
                     cnt_in = '0;
                  end
               end
               default: ;
            endcase
         end
         S_WB: begin
            if (wn_ff) begin
               ne_we = 1'b1;
               ne_wa = wna_ff[AW-1:0];
               ne_wd = wnd_ff;
            end
            if (wp_ff) begin
               pe_we = 1'b1;
               pe_wa = wpa_ff[AW-1:0];
               pe_wd = wpd_ff;
            end
            ve_ra = head_ff[AW-1:0];
            state_in = S_VAL_TAIL;
         end
         S_VAL_TAIL: begin
            fv_in = empty ? '0 : ve_rd;
            ve_ra = tail_ff[AW-1:0];
            state_in = S_VAL_CUR;
         end
         S_VAL_CUR: begin
            lv_in = empty ? '0 : ve_rd;
            ve_ra = cur_ff[AW-1:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_status = st_ff;
   assign rsp_first_value = fv_ff;
   assign rsp_last_value = lv_ff;
   assign rsp_cursor_value = (cur_ff >= NIL) ? '0 : ve_rd;
   assign rsp_length = LENGTH_W'(cnt_ff);
   assign rsp_is_empty = head_ff >= NIL;
   assign rsp_off_end = cur_ff >= NIL;
   assign rsp_at_first = cur_ff < NIL && cur_ff == head_ff;
   assign rsp_at_last = cur_ff < NIL && cur_ff == tail_ff;
endmodule
`default_nettype wire
